// ----- design/slcg_pkg.sv -----
`timescale 1ns / 1ps
// Package for the shuffled LCG ranged random unit.
// Holds the field widths, generator constants, opcodes and divider handshake types.
// No dependencies.
package slcg_pkg;

    localparam int VAL_W          = 20;      // generator and table value width
    localparam int DVD_W          = 33;      // divider dividend / quotient width
    localparam int DVS_W          = 21;      // divider divisor / remainder width
    localparam int SPAN_W         = 17;      // width of a non-empty range size
    localparam int NUM_W          = 16;      // range ends and result width
    localparam int SEED_W         = 32;
    localparam int LCG_SHIFT      = 12;      // multiply by 4096
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd150889;
    localparam int DRAW_TRY_LIMIT = 256;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int MODULUS_DEF     = 714025;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- design/slcg_cmd_if.sv -----
`timescale 1ns / 1ps
// Command channel of the shuffled LCG ranged random unit: reseed and draw transactions.
// Depends on slcg_pkg.
interface slcg_cmd_if;
    import slcg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [SEED_W-1:0]        seed;
    logic signed [NUM_W-1:0]  lowest;
    logic signed [NUM_W-1:0]  highest;

    modport source (output valid, output opcode, output seed, output lowest,
                    output highest, input ready);
    modport sink   (input valid, input opcode, input seed, input lowest,
                    input highest, output ready);
endinterface

// ----- design/slcg_res_if.sv -----
`timescale 1ns / 1ps
// Result channel of the shuffled LCG ranged random unit: one drawn number per transaction.
// Depends on slcg_pkg.
interface slcg_res_if;
    import slcg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

// ----- design/slcg_div.sv -----
`timescale 1ns / 1ps
// Shared radix-2 restoring divider: one quotient bit per cycle, DVD_W steps per operation.
// Depends on slcg_pkg for widths and the request/response structs.
module slcg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  slcg_pkg::div_req_t req,
    output slcg_pkg::div_rsp_t rsp
);
    import slcg_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift in one quotient bit per step; the dividend register ends up holding the quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- design/shuffled_lcg_ranged_random_unit.sv -----
`timescale 1ns / 1ps
// Top level of the shuffled LCG ranged random unit: sequencer, shuffle table and result register.
// Depends on slcg_pkg, slcg_cmd_if, slcg_res_if and slcg_div.
//
// Usage:
//   cmd carries reseed (opcode 0, seed) and draw (opcode 1, lowest, highest) transactions.
//   res carries one signed number per draw; a reseed gives no result.
//   The unit takes one command at a time: cmd.ready is high only while the sequencer is idle.
//   Every division and every generator step runs on one shared divider that retires one
//   quotient bit a cycle; a division runs as a launch, 33 steps and a done.
//   An empty-range draw skips the divider and goes straight to the final state. A reseed
//   runs one division per table slot plus two. Any other draw runs one division for the
//   partition size, two per try and one for the quotient; tries is 1 unless values are
//   rejected, at most 256.
//   A finished result sits in an output register; the sequencer returns to idle and
//   accepts the next command while that result waits. If the receiver stalls with a
//   result still held, the next draw holds in its final state until the register frees.
//   Reset clears the generator state and the table valid bits at once (an invalid slot
//   reads as zero), so no clearing pass is needed and a command may follow immediately.
module shuffled_lcg_ranged_random_unit #(
    parameter int TABLE_SLOTS = slcg_pkg::TABLE_SLOTS_DEF,
    parameter int MODULUS     = slcg_pkg::MODULUS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    slcg_cmd_if.sink   cmd,
    slcg_res_if.source res
);
    import slcg_pkg::*;

    localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SLOT_CMP_W = SLOT_W + 1;
    localparam int TRY_W      = $clog2(DRAW_TRY_LIMIT);
    localparam int PROD_W     = VAL_W + SPAN_W;
    localparam logic [TRY_W-1:0]  TRY_MAX   = TRY_W'(DRAW_TRY_LIMIT - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [DVS_W-1:0]  MOD_DVS   = DVS_W'(MODULUS);
    localparam logic [DVD_W-1:0]  MOD_M1    = DVD_W'(MODULUS - 1);
    localparam logic [DVD_W-1:0]  SLOTS_DVD = DVD_W'(TABLE_SLOTS);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_SEED     = 10'b0000000010,  // seed distance mod MODULUS
        S_FILL     = 10'b0000000100,  // one generator step per table slot, top down
        S_FILL_CUR = 10'b0000001000,  // one more step for the current value
        S_PART     = 10'b0000010000,  // partition size
        S_SLOT     = 10'b0000100000,  // slot index from current value
        S_READ     = 10'b0001000000,  // table read
        S_LCG      = 10'b0010000000,  // fresh generator value into the slot
        S_QUOT     = 10'b0100000000,  // value / partition size
        S_FIN      = 10'b1000000000   // hand the result to the output register
    } state_t;

    state_t             state_reg, state_next;
    logic               launch_reg, launch_next;
    logic [VAL_W-1:0]   chain_reg, chain_next;
    logic [VAL_W-1:0]   cur_reg, cur_next;
    logic [VAL_W-1:0]   part_reg, part_next;
    logic [VAL_W-1:0]   limit_reg, limit_next;
    logic [SPAN_W-1:0]  span_reg, span_next;
    logic [NUM_W-1:0]   lo_reg, lo_next;
    logic [SEED_W-1:0]  seed_abs_reg, seed_abs_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [TRY_W-1:0]   try_reg, try_next;
    logic [NUM_W-1:0]   res_num_reg, res_num_next;
    logic               out_vld_reg, out_vld_next;
    logic [NUM_W-1:0]   number_reg, number_next;

    // shuffle table with one valid bit per slot
    logic [VAL_W-1:0]       table_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] tbl_vld_reg;
    logic [VAL_W-1:0]       rd_data_reg;
    logic                   rd_vld_reg;
    logic                   tbl_we;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [SPAN_W:0] span_s;
    logic [DVD_W-1:0]       lcg_dvd;
    logic [SPAN_W-1:0]      span_m1;
    logic [NUM_W-1:0]       q_sat;

    slcg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // range size, two bits wider than the 16-bit ends so a difference plus one cannot overflow
    assign span_s = {{2{cmd.highest[NUM_W-1]}}, cmd.highest}
                  - {{2{cmd.lowest[NUM_W-1]}}, cmd.lowest} + (SPAN_W+1)'(1);

    // x * 4096 + 150889 before the modulo
    assign lcg_dvd = DVD_W'({chain_reg, {LCG_SHIFT{1'b0}}}) + DVD_W'(LCG_ADD);

    assign span_m1 = span_reg - 1'b1;
    assign q_sat   = (div_rsp.quotient > DVD_W'(span_m1)) ? span_m1[NUM_W-1:0]
                                                          : div_rsp.quotient[NUM_W-1:0];

    assign cmd.ready  = (state_reg == S_IDLE);
    assign res.valid  = out_vld_reg;
    assign res.number = number_reg;

    // divider operands follow the state; start only in the launch cycle of a state
    always_comb
    begin
        div_req.start    = launch_reg;
        div_req.dividend = lcg_dvd;
        div_req.divisor  = MOD_DVS;
        case (state_reg)
            S_SEED:
            begin
                div_req.dividend = DVD_W'(seed_abs_reg);
            end
            S_PART:
            begin
                div_req.dividend = MOD_M1;
                div_req.divisor  = DVS_W'(span_reg);
            end
            S_SLOT:
            begin
                div_req.dividend = SLOTS_DVD * DVD_W'(cur_reg);
            end
            S_QUOT:
            begin
                div_req.dividend = DVD_W'(cur_reg);
                div_req.divisor  = DVS_W'(part_reg);
            end
            default:
            begin
                div_req.dividend = lcg_dvd;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        launch_next   = 1'b0;
        chain_next    = chain_reg;
        cur_next      = cur_reg;
        part_next     = part_reg;
        limit_next    = limit_reg;
        span_next     = span_reg;
        lo_next       = lo_reg;
        seed_abs_next = seed_abs_reg;
        slot_next     = slot_reg;
        try_next      = try_reg;
        res_num_next  = res_num_reg;
        number_next   = number_reg;
        tbl_we        = 1'b0;
        // drop the held result once the receiver takes it
        out_vld_next  = out_vld_reg && !res.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.opcode == OP_RESEED)
                    begin
                        seed_abs_next = (cmd.seed >= LCG_ADD) ? cmd.seed - LCG_ADD
                                                              : LCG_ADD - cmd.seed;
                        state_next    = S_SEED;
                        launch_next   = 1'b1;
                    end
                    else if (span_s[SPAN_W] || span_s == '0)
                    begin
                        // empty range: answer lowest, leave the generator alone
                        res_num_next = cmd.lowest;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        span_next   = span_s[SPAN_W-1:0];
                        lo_next     = cmd.lowest;
                        state_next  = S_PART;
                        launch_next = 1'b1;
                    end
                end
            end
            S_SEED:
            begin
                if (!launch_reg && div_rsp.done)
                begin
                    chain_next  = div_rsp.remainder[VAL_W-1:0];
                    slot_next   = SLOT_LAST;
                    state_next  = S_FILL;
                    launch_next = 1'b1;
                end
            end
            S_FILL:
            begin
                if (!launch_reg && div_rsp.done)
                begin
                    chain_next  = div_rsp.remainder[VAL_W-1:0];
                    tbl_we      = 1'b1;
                    launch_next = 1'b1;
                    if (slot_reg == '0)
                    begin
                        state_next = S_FILL_CUR;
                    end
                    else
                    begin
                        slot_next = slot_reg - 1'b1;
                    end
                end
            end
            S_FILL_CUR:
            begin
                if (!launch_reg && div_rsp.done)
                begin
                    chain_next = div_rsp.remainder[VAL_W-1:0];
                    cur_next   = div_rsp.remainder[VAL_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_PART:
            begin
                if (!launch_reg && div_rsp.done)
                begin
                    // a range as wide as the modulus or wider gets partition size one
                    part_next   = (div_rsp.quotient == '0) ? VAL_W'(1)
                                                           : div_rsp.quotient[VAL_W-1:0];
                    try_next    = '0;
                    state_next  = S_SLOT;
                    launch_next = 1'b1;
                end
            end
            S_SLOT:
            begin
                if (launch_reg)
                begin
                    limit_next = VAL_W'(PROD_W'(part_reg) * PROD_W'(span_reg));
                end
                else if (div_rsp.done)
                begin
                    // saturate the slot index when the current value is out of range
                    slot_next  = (div_rsp.quotient >= SLOTS_DVD) ? SLOT_LAST
                                                                 : div_rsp.quotient[SLOT_W-1:0];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next  = S_LCG;
                launch_next = 1'b1;
            end
            S_LCG:
            begin
                if (launch_reg)
                begin
                    cur_next = rd_vld_reg ? rd_data_reg : '0;
                end
                else if (div_rsp.done)
                begin
                    chain_next  = div_rsp.remainder[VAL_W-1:0];
                    tbl_we      = 1'b1;
                    launch_next = 1'b1;
                    if (cur_reg < limit_reg || try_reg == TRY_MAX)
                    begin
                        state_next = S_QUOT;
                    end
                    else
                    begin
                        try_next   = try_reg + 1'b1;
                        state_next = S_SLOT;
                    end
                end
            end
            S_QUOT:
            begin
                if (!launch_reg && div_rsp.done)
                begin
                    res_num_next = lo_reg + q_sat;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_vld_reg || res.ready)
                begin
                    number_next  = res_num_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            launch_reg  <= 1'b0;
            chain_reg   <= '0;
            cur_reg     <= '0;
            slot_reg    <= '0;
            try_reg     <= '0;
            out_vld_reg <= 1'b0;
            tbl_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            chain_reg   <= chain_next;
            cur_reg     <= cur_next;
            slot_reg    <= slot_next;
            try_reg     <= try_next;
            out_vld_reg <= out_vld_next;
            if (tbl_we)
            begin
                tbl_vld_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg     <= part_next;
        limit_reg    <= limit_next;
        span_reg     <= span_next;
        lo_reg       <= lo_next;
        seed_abs_reg <= seed_abs_next;
        res_num_reg  <= res_num_next;
        number_reg   <= number_next;
    end

    // table port: write the fresh generator value, read with a registered output
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_mem[slot_reg] <= div_rsp.remainder[VAL_W-1:0];
        end
        rd_data_reg <= table_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= tbl_vld_reg[slot_reg];
        end
    end

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider launched while busy");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        SLOT_CMP_W'(slot_reg) < SLOT_CMP_W'(TABLE_SLOTS))
        else $error("slot index beyond table");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside the final state");

    a_draw_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUOT && launch_reg) |-> (cur_reg < limit_reg || try_reg == TRY_MAX))
        else $error("draw left the retry loop with a rejected value");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for shuffled_lcg_ranged_random_unit: directed table then random reseed and draw
// transactions, each drawn number checked against a local shuffled-generator predictor.
// Depends on slcg_pkg, slcg_cmd_if, slcg_res_if and the unit itself.
module tb;
    import slcg_pkg::*;

    localparam int SLOTS       = TABLE_SLOTS_DEF;
    localparam int MODULUS     = MODULUS_DEF;
    localparam int PLAN_ROWS   = 25;
    localparam int RANDOM_CMDS = 580;
    localparam int IDLE_PCT    = 23;
    // Slowest possible transaction is a draw that runs all 256 tries; the limit covers about
    // 600 of those plus idling, taken several times.
    localparam int CYCLE_LIMIT = 60_000_000;

    typedef struct packed {
        logic                    opcode;
        logic [SEED_W-1:0]       seed;
        logic signed [NUM_W-1:0] lowest;
        logic signed [NUM_W-1:0] highest;
    } rng_cmd_t;

    // A directed row; pinned rows carry a number that is plain from the range alone.
    typedef struct packed {
        rng_cmd_t                req;
        logic                    pinned;
        logic signed [NUM_W-1:0] pinned_number;
    } plan_row_t;

    logic clk;
    logic rst_n;

    slcg_cmd_if cmd_ch ();
    slcg_res_if res_ch ();

    shuffled_lcg_ranged_random_unit #(
        .TABLE_SLOTS (SLOTS),
        .MODULUS     (MODULUS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    // Predictor state: its own copy of the shuffle table and both generator registers.
    logic [VAL_W-1:0] shuffle_tbl [SLOTS];
    logic [VAL_W-1:0] current_val;
    logic [VAL_W-1:0] chain_val;

    logic signed [NUM_W-1:0] numbers_due [$];
    int                      faults = 0;
    int                      cycles = 0;
    bit                      steady;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Advance the congruential chain by one step.
    function automatic logic [VAL_W-1:0] chain_step(input logic [VAL_W-1:0] x);
        logic [63:0] v;
        v = (64'(x) << LCG_SHIFT) + 64'(LCG_ADD);
        return VAL_W'(v % 64'(MODULUS));
    endfunction

    // Apply one transaction to the predictor; return 1 and the number when it draws.
    function automatic bit next_number(input rng_cmd_t c,
                                       output logic signed [NUM_W-1:0] number);
        longint          gap;
        longint unsigned slot;
        int              lo;
        int              hi;
        int              span;
        int unsigned     part;
        int unsigned     limit;
        int unsigned     q;
        number = '0;
        if (c.opcode == OP_RESEED) begin
            gap = longint'(LCG_ADD) - longint'(c.seed);
            if (gap < 0)
                gap = -gap;
            chain_val = VAL_W'(gap % MODULUS);
            for (int j = SLOTS - 1; j >= 0; j--) begin
                chain_val      = chain_step(chain_val);
                shuffle_tbl[j] = chain_val;
            end
            chain_val   = chain_step(chain_val);
            current_val = chain_val;
            return 1'b0;
        end
        lo   = c.lowest;
        hi   = c.highest;
        span = hi - lo + 1;
        if (span <= 0) begin
            number = c.lowest;
            return 1'b1;
        end
        part = (MODULUS - 1) / span;
        if (part == 0)
            part = 1;
        limit = part * span;
        for (int tries = 0; tries < DRAW_TRY_LIMIT; tries++) begin
            slot = (longint'(SLOTS) * current_val) / MODULUS;
            if (slot >= SLOTS)
                slot = SLOTS - 1;
            current_val       = shuffle_tbl[slot];
            chain_val         = chain_step(chain_val);
            shuffle_tbl[slot] = chain_val;
            if (current_val < limit)
                break;
        end
        q = current_val / part;
        if (q > span - 1)
            q = span - 1;
        number = NUM_W'(lo + int'(q));
        return 1'b1;
    endfunction

    // Both sides take a break with a chance of about 23 in a hundred, except during the steady stretch.
    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Present one transaction and hold it until the unit takes it. With drain set,
    // hold valid low until every outstanding number has come back.
    task automatic send_cmd(input rng_cmd_t c, input bit drain, input bit pinned,
                            input logic signed [NUM_W-1:0] pinned_number);
        logic signed [NUM_W-1:0] number;
        if (drain || take_break())
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
            while ((drain && numbers_due.size() != 0) || take_break())
                @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= c.opcode;
        cmd_ch.seed    <= c.seed;
        cmd_ch.lowest  <= c.lowest;
        cmd_ch.highest <= c.highest;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        // Accepted at this edge: run the predictor so its state tracks the unit.
        if (next_number(c, number))
            numbers_due.push_back(pinned ? pinned_number : number);
    endtask

    // Result side: check each accepted number against the oldest expectation,
    // then decide whether to stall the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (numbers_due.size() == 0)
            begin
                $display("%0t: unexpected number: expected none, actual %0d",
                         $time, res_ch.number);
                faults++;
            end
            else if (res_ch.number !== numbers_due[0])
            begin
                $display("%0t: number mismatch: expected %0d, actual %0d",
                         $time, numbers_due[0], res_ch.number);
                faults++;
                void'(numbers_due.pop_front());
            end
            else
                void'(numbers_due.pop_front());
        end
        res_ch.ready <= rst_n && !take_break();
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        plan_row_t               plan [PLAN_ROWS];
        rng_cmd_t                c;
        int                      pick;
        int                      top;
        logic signed [NUM_W-1:0] swap;

        steady         = 1'b0;
        current_val    = '0;
        chain_val      = '0;
        foreach (shuffle_tbl[i])
            shuffle_tbl[i] = '0;
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.opcode  = OP_RESEED;
        cmd_ch.seed    = '0;
        cmd_ch.lowest  = '0;
        cmd_ch.highest = '0;

        // Extremes of the range, empty ranges, single-value ranges, and reseeds whose
        // difference to the additive constant is zero, negative and large.
        plan = '{
            '{'{OP_DRAW,   32'd0,          16'sd5,      16'sd5     }, 1'b1, 16'sd5     },
            '{'{OP_DRAW,   32'd0,          16'sh7FFF,   16'sh8000  }, 1'b1, 16'sh7FFF  },
            '{'{OP_DRAW,   32'd0,          16'sh8000,   16'sh7FFF  }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sh8000,   16'sh8000  }, 1'b1, 16'sh8000  },
            '{'{OP_RESEED, 32'd0,          16'sd0,      16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sd0,      16'sd1     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          -16'sd1,     16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sd0,      -16'sd1    }, 1'b1, 16'sd0     },
            '{'{OP_RESEED, 32'd150889,     16'sd0,      16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sh8000,   16'sh7FFF  }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sh7FFF,   16'sh7FFF  }, 1'b1, 16'sh7FFF  },
            '{'{OP_RESEED, 32'hFFFF_FFFF,  16'sd0,      16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sh8000,   16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sd0,      16'sh7FFF  }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sd1,      16'sd0     }, 1'b1, 16'sd1     },
            '{'{OP_RESEED, 32'd150890,     16'sd0,      16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          -16'sd100,   16'sd100   }, 1'b0, 16'sd0     },
            '{'{OP_RESEED, 32'h8000_0000,  16'sd0,      16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sh8000,   16'sh7FFF  }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sh8000,   16'sh7FFF  }, 1'b0, 16'sd0     },
            '{'{OP_RESEED, 32'h5555_5555,  16'sd0,      16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sh8000,   16'sh8001  }, 1'b0, 16'sd0     },
            '{'{OP_RESEED, 32'hAAAA_AAAA,  16'sd0,      16'sd0     }, 1'b0, 16'sd0     },
            '{'{OP_DRAW,   32'd0,          16'sd100,    16'sd99    }, 1'b1, 16'sd100   },
            '{'{OP_DRAW,   32'd0,          -16'sd7,     16'sd7     }, 1'b0, 16'sd0     }
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: walk the table right after reset.
        foreach (plan[i])
            send_cmd(plan[i].req, 1'b0, plan[i].pinned, plan[i].pinned_number);

        // Random part: mostly draws over varied ranges, a few reseeds.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            steady    = (n >= 100) && (n < 250);
            pick      = $urandom_range(0, 99);
            c.opcode  = OP_DRAW;
            c.seed    = $urandom;
            c.lowest  = NUM_W'($urandom);
            c.highest = NUM_W'($urandom);
            if (pick < 8)
            begin
                c.opcode = OP_RESEED;
                // Land near the additive constant now and then, both sides of it.
                if (pick < 2)
                    c.seed = LCG_ADD + $urandom_range(0, 16) - 8;
            end
            else if (pick < 15)
            begin
                // Force an empty range.
                if (c.highest >= c.lowest)
                begin
                    if (c.highest == c.lowest)
                        c.highest = NUM_W'(c.lowest - 1);
                    else
                    begin
                        swap      = c.lowest;
                        c.lowest  = c.highest;
                        c.highest = swap;
                    end
                    if (c.highest >= c.lowest)
                    begin
                        c.lowest  = 16'sh7FFF;
                        c.highest = 16'sh8000;
                    end
                end
            end
            else if (pick < 50)
            begin
                // Wide non-empty range; these see the most rejections.
                if (c.highest < c.lowest)
                begin
                    swap      = c.lowest;
                    c.lowest  = c.highest;
                    c.highest = swap;
                end
            end
            else if (pick < 80)
            begin
                // Narrow range of up to sixteen values.
                top = int'(c.lowest) + $urandom_range(0, 15);
                c.highest = (top > 32767) ? 16'sh7FFF : NUM_W'(top);
            end
            // Otherwise keep the raw pair, empty or not.
            send_cmd(c, n == 300, 1'b0, '0);
        end

        // Drain: hold off, wait out every outstanding number and some slack after.
        cmd_ch.valid <= 1'b0;
        while (numbers_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (faults == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
